// ----- rtl/rbd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and slot helpers for the ring buffer deque.
// Used by the channel interfaces, the controller, the datapath and the top level.
package rbd_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int ACT_W  = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    typedef logic [PTR_W-1:0]      t_slot;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ_IDX   = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;      // apply the accepted beat to the pointers and store
        logic cap_idx;   // capture the indexed read data
        logic load_out;  // load the result register
    } t_rbd_cmd;

    // Advance a slot by one, wrapping at the end of the ring
    function automatic t_slot slot_next(input t_slot s);
        t_slot r;
        if (s == t_slot'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + t_slot'(1);
        end
        return r;
    endfunction

    // Step a slot back by one, wrapping at the start of the ring
    function automatic t_slot slot_prev(input t_slot s);
        t_slot r;
        if (s == '0) begin
            r = t_slot'(DEPTH - 1);
        end else begin
            r = s - t_slot'(1);
        end
        return r;
    endfunction

    // Add an offset below DEPTH to a slot, modulo DEPTH
    function automatic t_slot slot_add(input t_slot s, input t_slot off);
        logic [PTR_W:0] sum;
        sum = {1'b0, s} + {1'b0, off};
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ----- rtl/rbd_in_if.sv -----
`timescale 1ns / 1ps
// Request channel of the ring buffer deque: valid/ready plus one command beat.
// Depends on rbd_pkg for field widths.
interface rbd_in_if;
    import rbd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [DATA_WIDTH-1:0]   push_value;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output action, output push_value, output position,
                    input ready);
    modport sink   (input valid, input action, input push_value, input position,
                    output ready);
endinterface

// ----- rtl/rbd_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the ring buffer deque: valid/ready plus one result beat.
// Depends on rbd_pkg for field widths.
interface rbd_out_if;
    import rbd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STAT_W-1:0]     status;
    logic [DATA_WIDTH-1:0] read_value;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_empty;

    modport source (output valid, output status, output read_value, output front_value,
                    output back_value, output occupancy, output is_empty, input ready);
    modport sink   (input valid, input status, input read_value, input front_value,
                    input back_value, input occupancy, input is_empty, output ready);
endinterface

// ----- rtl/rbd_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the ring buffer deque: input/output handshakes and datapath commands.
// Depends on rbd_pkg for the command struct.
module rbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rbd_pkg::t_rbd_cmd o_cmd
);
    import rbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;
    logic   load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    // Load the result register once it is free or being emptied this cycle
    assign load        = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    assign o_cmd.exec     = in_fire;
    assign o_cmd.cap_idx  = (r_state == S_READ);
    assign o_cmd.load_out = load;

    // Next state: accept, wait for the indexed read, then load the result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/rbd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the ring buffer deque: pointers, count, the two-read-port ring store
// and the result register. Depends on rbd_pkg; driven by rbd_ctrl commands.
module rbd_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rbd_pkg::t_rbd_cmd                i_cmd,
    input  logic [rbd_pkg::ACT_W-1:0]        i_action,
    input  logic [rbd_pkg::DATA_WIDTH-1:0]   i_push_value,
    input  logic signed [rbd_pkg::POS_W-1:0] i_position,
    output logic [rbd_pkg::STAT_W-1:0]       o_status,
    output logic [rbd_pkg::DATA_WIDTH-1:0]   o_read_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0]   o_front_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0]   o_back_value,
    output logic [rbd_pkg::CNT_W-1:0]        o_occupancy,
    output logic                             o_is_empty
);
    import rbd_pkg::*;

    localparam int IDX_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Ring store, two registered read ports
    t_data mem [DEPTH];
    t_data r_rd_a, r_rd_b;
    t_slot rd_a_addr;

    // Control state
    t_slot  r_head, n_head;
    t_slot  r_tail, n_tail;
    t_count r_count, n_count;

    // Per-beat results awaiting the store reads
    t_status r_stat, n_stat;
    logic    r_is_read, n_is_read;
    t_data   r_idx_val;

    // Result register
    t_status r_o_status;
    t_data   r_o_read, r_o_front, r_o_back;
    t_count  r_o_count;

    logic    wr_en;
    t_slot   wr_addr;
    t_action act;

    logic signed [IDX_W-1:0] pos_x, cnt_x, pos_sum;
    logic                    pos_neg, idx_ok;
    t_slot                   idx_slot;

    assign act = t_action'(i_action);

    // Map a signed position onto a slot; negative counts back from the rear
    always_comb begin
        pos_x    = IDX_W'(i_position);
        cnt_x    = IDX_W'(r_count);
        pos_sum  = pos_x + cnt_x;
        pos_neg  = i_position[POS_W-1];
        idx_ok   = pos_neg ? !pos_sum[IDX_W-1] : (pos_x < cnt_x);
        idx_slot = slot_add(r_head, pos_neg ? pos_sum[PTR_W-1:0] : pos_x[PTR_W-1:0]);
    end

    // Decode the action into pointer, count and store updates
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_stat    = ST_OK;
        n_is_read = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        unique case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                if (r_count == t_count'(DEPTH)) begin
                    n_stat = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + t_count'(1);
                    if (r_count == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (act == ACT_PUSH_BACK) begin
                        n_tail  = slot_next(r_tail);
                        wr_addr = slot_next(r_tail);
                    end else begin
                        n_head  = slot_prev(r_head);
                        wr_addr = slot_prev(r_head);
                    end
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT: begin
                if (r_count == '0) begin
                    n_stat = ST_EMPTY;
                end else if (r_count == t_count'(1)) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end else begin
                    n_count = r_count - t_count'(1);
                    if (act == ACT_POP_BACK) begin
                        n_tail = slot_prev(r_tail);
                    end else begin
                        n_head = slot_next(r_head);
                    end
                end
            end
            ACT_READ_IDX: begin
                if (r_count == '0) begin
                    n_stat = ST_EMPTY;
                end else if (!idx_ok) begin
                    n_stat = ST_RANGE;
                end else begin
                    n_is_read = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Port A serves the indexed read while executing, the front slot otherwise
    assign rd_a_addr = i_cmd.exec ? idx_slot : r_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= i_push_value;
        end
        r_rd_a <= mem[rd_a_addr];
        r_rd_b <= mem[r_tail];
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Hold status and indexed data until the result is loaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_stat    <= n_stat;
            r_is_read <= n_is_read;
        end
        if (i_cmd.cap_idx) begin
            r_idx_val <= r_is_read ? r_rd_a : '0;
        end
    end

    // Load the result beat; front and back read as zero when empty
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_stat;
            r_o_read   <= r_idx_val;
            r_o_front  <= (r_count == '0) ? '0 : r_rd_a;
            r_o_back   <= (r_count == '0) ? '0 : r_rd_b;
            r_o_count  <= r_count;
        end
    end

    assign o_status      = r_o_status;
    assign o_read_value  = r_o_read;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_occupancy   = r_o_count;
    assign o_is_empty    = (r_o_count == '0);

endmodule

// ----- rtl/ring_buffer_deque.sv -----
`timescale 1ns / 1ps
// Ring buffer deque: push/pop at either end, signed indexed read and clear over a
// fixed ring of DEPTH entries, one result beat per request beat. Each request passes
// three steps from acceptance to a loaded result (execute with the indexed read
// issued, capture the indexed data while reading the front and back slots, load the
// result), set by the registered read ports of the ring store; a request is accepted
// again in the cycle after the load, even while the previous result still waits to be
// taken. A push on a full ring returns a full status and changes nothing; popping or
// reading an empty deque returns an empty status; a position outside the stored span
// returns an out-of-range status. Front and back values read as zero when empty.
// Depends on rbd_pkg, rbd_in_if, rbd_out_if, rbd_ctrl and rbd_datapath.
module ring_buffer_deque (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbd_in_if.sink     i_in_ch,
    rbd_out_if.source  o_out_ch
);
    import rbd_pkg::*;

    t_rbd_cmd cmd;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (cmd)
    );

    rbd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_in_ch.action),
        .i_push_value  (i_in_ch.push_value),
        .i_position    (i_in_ch.position),
        .o_status      (o_out_ch.status),
        .o_read_value  (o_out_ch.read_value),
        .o_front_value (o_out_ch.front_value),
        .o_back_value  (o_out_ch.back_value),
        .o_occupancy   (o_out_ch.occupancy),
        .o_is_empty    (o_out_ch.is_empty)
    );

endmodule
